// ===== design/min_max_normalizer_core_defines.svh =====
// Assertion macros for the min-max normalizer core.
// Included by the controller and datapath; needs no other file.
`ifndef MIN_MAX_NORMALIZER_CORE_DEFINES_SVH
`define MIN_MAX_NORMALIZER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked at every rising edge outside reset
`define MMN_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen outside reset
`define MMN_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MMN_ASSERT(lbl, clk, rst_n, prop, msg)
`define MMN_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== design/mmn_pkg.sv =====
// Shared constants, function codes and control types of the min-max normalizer.
// Used by mmn_ctrl, mmn_dp and min_max_normalizer_core; depends on nothing.
package mmn_pkg;

	// Sizing
	localparam int FEATURE_COUNT = 4;
	localparam int FRACTION_BITS = 16;
	localparam int LANES         = 4;
	localparam int FEAT_W        = 32;
	localparam int NORM_W        = 17;
	localparam int FUNC_W        = 2;
	localparam int CNT_W         = $clog2(FRACTION_BITS + 1);
	localparam int IN_TDATA_W    = ((LANES * FEAT_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W   = ((LANES * NORM_W + 7) / 8) * 8;

	// 1.0 in the output format, cut to the field width
	localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(64'd1 << FRACTION_BITS);

	// Statistic reset values
	localparam logic signed [FEAT_W-1:0] MIN_RESET = {1'b0, {(FEAT_W-1){1'b1}}};
	localparam logic signed [FEAT_W-1:0] MAX_RESET = {1'b1, {(FEAT_W-1){1'b0}}};

	// Function codes carried in tuser
	localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_MEASURE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SCALE   = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic clear;
		logic measure;
		logic load;
		logic step;
		logic emit;
	} mmn_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} mmn_sts_t;

endpackage

// ===== design/mmn_ctrl.sv =====
// Controller of the min-max normalizer: request decode and divider sequencing.
// Depends on mmn_pkg and min_max_normalizer_core_defines.svh.
`include "min_max_normalizer_core_defines.svh"

module mmn_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [mmn_pkg::FUNC_W-1:0]    in_func,
	output logic                          in_ready,
	input  mmn_pkg::mmn_sts_t             sts,
	output mmn_pkg::mmn_cmd_t             cmd
);
	import mmn_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             div_done;

	// Decode and sequencing
	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		accept      = in_valid && in_ready;
		div_done    = (cnt_q == CNT_W'(FRACTION_BITS));
		cmd         = '0;
		cmd.clear   = accept && (in_func == FUNC_CLEAR);
		cmd.measure = accept && (in_func == FUNC_MEASURE);
		cmd.load    = accept && (in_func == FUNC_SCALE);
		cmd.step    = (state_q == ST_DIV) && !div_done;
		cmd.emit    = (state_q == ST_DIV) && div_done && sts.out_free;
	end

	// State and quotient bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (cmd.step) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (cmd.emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`MMN_ASSERT(a_load_starts_div, clk, arst_n, cmd.load |=> (state_q == ST_DIV && cnt_q == '0), "scale request did not start the divider")
	`MMN_ASSERT(a_emit_after_all_bits, clk, arst_n, cmd.emit |-> (cnt_q == CNT_W'(FRACTION_BITS)), "result emitted before all quotient bits")
	`MMN_ASSERT_NEVER(a_no_load_while_div, clk, arst_n, (state_q == ST_DIV) && (cmd.load || cmd.measure || cmd.clear), "request taken while dividing")

endmodule

// ===== design/mmn_dp.sv =====
// Datapath of the min-max normalizer: statistics, four restoring divider
// lanes and the output register. Depends on mmn_pkg and the defines header.
`include "min_max_normalizer_core_defines.svh"

module mmn_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mmn_pkg::mmn_cmd_t                  cmd,
	output mmn_pkg::mmn_sts_t                  sts,
	input  logic [mmn_pkg::IN_TDATA_W-1:0]     in_data,
	input  logic                               in_last,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [mmn_pkg::OUT_TDATA_W-1:0]    out_data,
	output logic                               out_last
);
	import mmn_pkg::*;

	// Statistics
	logic signed [FEAT_W-1:0]   min_q [LANES];
	logic signed [FEAT_W-1:0]   max_q [LANES];
	logic signed [FEAT_W-1:0]   feat  [LANES];

	// Divider lanes
	logic [FEAT_W-1:0]          rem_q  [LANES];
	logic [FEAT_W-1:0]          den_q  [LANES];
	logic [FRACTION_BITS-1:0]   quo_q  [LANES];
	logic [LANES-1:0]           zero_q;
	logic [LANES-1:0]           one_q;
	logic                       last_q;

	// Setup values and one divider step per lane
	logic signed [FEAT_W:0]     off_full [LANES];
	logic signed [FEAT_W:0]     rng_full [LANES];
	logic [LANES-1:0]           zero_d;
	logic [LANES-1:0]           one_d;
	logic [FEAT_W+1:0]          trial    [LANES];
	logic [FEAT_W-1:0]          rem_d    [LANES];
	logic [LANES-1:0]           qbit_d;

	// Output register
	logic [NORM_W-1:0]          norm_q [LANES];
	logic [LANES*NORM_W-1:0]    norm_vec;
	logic                       out_valid_q;
	logic                       out_last_q;

	always_comb begin
		for (int f = 0; f < LANES; f++) begin
			feat[f]     = in_data[f*FEAT_W +: FEAT_W];
			off_full[f] = (FEAT_W+1)'(feat[f]) - (FEAT_W+1)'(min_q[f]);
			rng_full[f] = (FEAT_W+1)'(max_q[f]) - (FEAT_W+1)'(min_q[f]);
			// Empty range, point at or below minimum, or unused lane
			zero_d[f]   = (f >= FEATURE_COUNT) || !(max_q[f] > min_q[f]) || !(feat[f] > min_q[f]);
			// Point at or above maximum saturates
			one_d[f]    = (feat[f] >= max_q[f]);
			// Restoring step: remainder stays below the divisor if it starts below it
			trial[f]    = {1'b0, rem_q[f], 1'b0} - {2'b00, den_q[f]};
			qbit_d[f]   = !trial[f][FEAT_W+1];
			rem_d[f]    = qbit_d[f] ? trial[f][FEAT_W-1:0] : {rem_q[f][FEAT_W-2:0], 1'b0};
		end
	end

	// Per-feature minimum and maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int f = 0; f < LANES; f++) begin
				min_q[f] <= MIN_RESET;
				max_q[f] <= MAX_RESET;
			end
		end else if (cmd.clear) begin
			for (int f = 0; f < LANES; f++) begin
				min_q[f] <= MIN_RESET;
				max_q[f] <= MAX_RESET;
			end
		end else if (cmd.measure) begin
			for (int f = 0; f < LANES; f++) begin
				if (f < FEATURE_COUNT) begin
					if (feat[f] < min_q[f]) min_q[f] <= feat[f];
					if (feat[f] > max_q[f]) max_q[f] <= feat[f];
				end
			end
		end
	end

	// Divider load and iteration
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int f = 0; f < LANES; f++) begin
				rem_q[f] <= off_full[f][FEAT_W-1:0];
				den_q[f] <= rng_full[f][FEAT_W-1:0];
				quo_q[f] <= '0;
			end
			zero_q <= zero_d;
			one_q  <= one_d;
			last_q <= in_last;
		end else if (cmd.step) begin
			for (int f = 0; f < LANES; f++) begin
				rem_q[f] <= rem_d[f];
				quo_q[f] <= {quo_q[f][FRACTION_BITS-2:0], qbit_d[f]};
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			for (int f = 0; f < LANES; f++) begin
				if (zero_q[f]) begin
					norm_q[f] <= '0;
				end else if (one_q[f]) begin
					norm_q[f] <= NORM_ONE;
				end else begin
					norm_q[f] <= NORM_W'(quo_q[f]);
				end
			end
			out_last_q <= last_q;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		for (int f = 0; f < LANES; f++) begin
			norm_vec[f*NORM_W +: NORM_W] = norm_q[f];
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = OUT_TDATA_W'(norm_vec);
	assign out_last     = out_last_q;

	`MMN_ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.emit && out_valid_q && !out_ready, "result overwritten before taken")
	`MMN_ASSERT(a_stats_ordered, clk, arst_n, $past(cmd.measure) |-> (min_q[0] <= max_q[0]), "minimum above maximum after measure")
	`MMN_ASSERT_NEVER(a_load_step_clash, clk, arst_n, cmd.load && (cmd.step || cmd.emit), "divider loaded while iterating")

endmodule

// ===== design/min_max_normalizer_core.sv =====
// Min-max normalizer core: four-feature streaming top level.
// Depends on mmn_pkg, mmn_ctrl and mmn_dp.
//
// Requests arrive on the s_axis channel with a function code in tuser: clear
// resets the per-feature minimum and maximum, measure folds a point into
// them, scale returns one result on m_axis with each feature as
// (x - min) / (max - min) in unsigned Q1.16, clamped to [0, 1.0], and 0 for a
// feature whose range is empty. Clear, measure and unknown codes give no
// result. A scale request loads the four per-lane restoring dividers on
// acceptance; they produce one quotient bit per cycle, and the finished
// quotients are loaded into the output register before the next request can
// be taken. The output register holds a finished result while new requests
// are accepted; a scale request waits in the divider only if the previous
// result has not yet been taken.
module min_max_normalizer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// feature_0 [31:0], feature_1 [63:32], feature_2 [95:64], feature_3 [127:96]
	input  logic [mmn_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// func [1:0]
	input  logic [mmn_pkg::FUNC_W-1:0]          s_axis_tuser,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// norm_0 [16:0], norm_1 [33:17], norm_2 [50:34], norm_3 [67:51], zeros above
	output logic [mmn_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tlast
);
	import mmn_pkg::*;

	mmn_cmd_t cmd;
	mmn_sts_t sts;

	mmn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_func  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mmn_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
